@@ hdl/smbd_pkg.sv @@
// Shared constants, register codes and table builders for the sRGB mip box downsampler.
// No dependencies; smbd_cfg_if, smbd_enc_rom and the top level import this package.
package smbd_pkg;

  localparam int MAX_WIDTH_DEF       = 4096;
  localparam int LINEAR_BITS_DEF     = 16;
  localparam int SRGB_INDEX_BITS_DEF = 12;

  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_BITS       = 12;
  localparam int DIM_BITS       = 13;
  localparam int REG_INDEX_BITS = 2;
  localparam int LIN_TAB_BITS   = 24;

  localparam logic [REG_INDEX_BITS-1:0] REG_LEVEL_WIDTH  = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_LEVEL_HEIGHT = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_SRGB_MODE    = 2'd2;

  localparam logic [DIM_BITS-1:0] LEVEL_WIDTH_RST  = 13'd4096;
  localparam logic [DIM_BITS-1:0] LEVEL_HEIGHT_RST = 13'd4096;

  typedef logic [255:0][LIN_TAB_BITS-1:0] lin_tab_t;

  // Q30 product, truncated
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // sRGB to linear curve in Q30 for half-step code k (s = k/510)
  function automatic logic [63:0] curve_q30(int unsigned k);
    logic [63:0] kk, x, x4, x12, lo, hi, mid, y2, y5;
    kk = 64'(k);
    if (k <= 20) begin
      return (((kk * 64'd100) << 30) + 64'd329460) / 64'd658920;
    end
    x   = (((kk * 64'd1000 + 64'd28050) << 30) + 64'd269025) / 64'd538050;
    x4  = qmul(qmul(x, x), qmul(x, x));
    x12 = qmul(qmul(x4, x4), x4);
    lo  = 64'd0;
    hi  = 64'd1 << 30;
    // largest Y whose truncated fifth power stays at or below X^12
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      y2  = qmul(mid, mid);
      y5  = qmul(qmul(y2, y2), mid);
      if (y5 <= x12) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // decode threshold between byte b-1 and byte b
  function automatic logic [63:0] threshold_q30(int unsigned b);
    if (b == 0) return 64'd0;
    return curve_q30(2 * b - 1);
  endfunction

  function automatic lin_tab_t lin_table(int unsigned lb);
    lin_tab_t    t;
    logic [63:0] m, v;
    m = (64'd1 << lb) - 64'd1;
    for (int b = 0; b < 256; b++) begin
      v    = (curve_q30(2 * b) * m + (64'd1 << 29)) >> 30;
      t[b] = v[LIN_TAB_BITS-1:0];
    end
    return t;
  endfunction

endpackage

@@ hdl/smbd_pix_in_if.sv @@
// Source pixel channel: valid/ready handshake with one RGBA8 pixel per beat.
// No dependencies.
interface smbd_pix_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

@@ hdl/smbd_pix_out_if.sv @@
// Downsampled pixel channel: valid/ready handshake, RGBA8 plus end-of-level flag.
// No dependencies.
interface smbd_pix_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       level_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output level_done, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, input level_done, output ready);
endinterface

@@ hdl/smbd_cfg_if.sv @@
// Register write channel: valid/ready, register index and write data.
// Depends on smbd_pkg for the field widths.
interface smbd_cfg_if import smbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REG_INDEX_BITS-1:0] index;
  logic [DIM_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/smbd_enc_rom.sv @@
// Linear-to-sRGB encode ROM for one colour channel, registered read.
// Depends on smbd_pkg for the curve thresholds.
module smbd_enc_rom import smbd_pkg::*; #(
  parameter int SRGB_INDEX_BITS = SRGB_INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [SRGB_INDEX_BITS-1:0] addr,
  output logic [7:0]                 data
);

  localparam int ENC_SIZE = 1 << SRGB_INDEX_BITS;

  typedef logic [ENC_SIZE-1:0][7:0] enc_tab_t;

  // entry i: the last byte whose lower threshold lies at or below the bucket centre
  function automatic enc_tab_t build_enc();
    enc_tab_t          t;
    logic [255:0][63:0] thr;
    logic [63:0]       r;
    int                b;
    for (int k = 0; k < 256; k++) begin
      thr[k] = threshold_q30(k);
    end
    b = 0;
    for (int i = 0; i < ENC_SIZE; i++) begin
      r = 64'(2 * i + 1) << (29 - SRGB_INDEX_BITS);
      while (b < 255 && thr[b + 1] <= r) b++;
      t[i] = 8'(b);
    end
    return t;
  endfunction

  localparam enc_tab_t ENC_TAB = build_enc();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= ENC_TAB[addr];
    end
  end

endmodule

@@ hdl/srgb_mip_box_downsample_top.sv @@
// Top level of the sRGB-aware 2x2 box mip downsampler.
// Depends on smbd_pkg, the three channel interfaces and smbd_enc_rom.
//
// Usage:
//   pix_in  - source pixels of one level in raster order, one per beat.
//   pix_out - one pixel per 2x2 source block, in raster order of the half-size
//             level; level_done marks the last pixel of that level.
//   cfg     - register writes (0 width, 1 height, 2 sRGB mode), always ready.
//             Writes to 0-2 restart the level; write only while the block is idle.
// Pipeline: the source pixel that completes a block passes the input register;
//   decode, pair add and column store access; column sum, average and encode ROM;
//   and the output register, from which its result beat is offered.
// Throughput: one source pixel per ready cycle. The column store is a single-port
//   memory touched at most once per pixel: written on even rows, read on odd rows.
// Reset: registers return to 4096 x 4096, sRGB on, position at the level start.
//   The column store is not cleared; every entry is written before it is used.
// Stall: while pix_out is held off the stages behind it keep filling; pix_in
//   drops ready only once all four stages hold data.
module srgb_mip_box_downsample_top import smbd_pkg::*; #(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int LINEAR_BITS     = LINEAR_BITS_DEF,
  parameter int SRGB_INDEX_BITS = SRGB_INDEX_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  smbd_pix_in_if.sink    pix_in,
  smbd_pix_out_if.source pix_out,
  smbd_cfg_if.sink       cfg
);

  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LB          = LINEAR_BITS;
  localparam int PW          = LB + 1;
  localparam int TW          = LB + 2;

  localparam lin_tab_t LIN_TAB = lin_table(LINEAR_BITS);

  typedef struct packed {
    logic          ld_left;
    logic          st_wr;
    logic          emit;
    logic          w_one;
    logic          h_one;
    logic          last;
    logic [AW-1:0] col;
  } s1_ctl_t;

  typedef struct packed {
    logic [2:0][PW-1:0] col;
    logic [8:0]         alpha;
  } sum_t;

  // registers
  logic [DIM_BITS-1:0] level_width;
  logic [DIM_BITS-1:0] level_height;
  logic                srgb_mode;
  logic [XW-1:0]       col_cnt;
  logic [ROW_BITS-1:0] row_cnt;

  // stage valids and handshake
  logic v1, v2, v3, out_valid;
  logic adv_out, adv3, adv2, in_ready, in_beat;

  // geometry
  logic [WW-1:0]       w_eff, dw;
  logic [DIM_BITS-1:0] h_eff, dh;
  logic                w_one, h_one, x_in, y_in, last_col, last_row, have;
  logic [XW-1:0]       col_half;
  logic [ROW_BITS-1:0] row_half;
  s1_ctl_t             ctl_next;

  // stage 1
  s1_ctl_t            s1;
  logic [2:0][7:0]    s1_col;
  logic [7:0]         s1_alpha;
  logic [2:0][LB-1:0] lin_c;
  logic [2:0][LB-1:0] left_col;
  logic [7:0]         left_alpha;
  sum_t               pair;

  // column store
  sum_t col_store [STORE_DEPTH];
  sum_t rd_q;

  // stage 2
  sum_t               pair2;
  logic               h_one2, last2;
  logic [2:0][TW-1:0] total_c;
  logic [2:0][LB-1:0] avg_c;
  logic [10:0]        total_a;
  logic [2:0][SRGB_INDEX_BITS-1:0] idx_c;

  // stage 3
  logic [2:0][7:0] enc_q;
  logic [2:0][7:0] lin3;
  logic [7:0]      alpha3;
  logic            last3;

  // output register
  logic [2:0][7:0] out_col;
  logic [7:0]      out_alpha;
  logic            out_last;

  assign adv_out  = !out_valid || pix_out.ready;
  assign adv3     = !v3 || adv_out;
  assign adv2     = !v2 || adv3;
  assign in_ready = !v1 || adv2;
  assign in_beat  = pix_in.valid && in_ready;

  assign pix_in.ready = in_ready;
  assign cfg.ready    = 1'b1;

  // effective geometry and what this pixel does
  always_comb begin
    if (level_width == '0) w_eff = WW'(1);
    else if (32'(level_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(level_width);

    if (level_height == '0) h_eff = DIM_BITS'(1);
    else if (32'(level_height) > MAX_HEIGHT) h_eff = DIM_BITS'(MAX_HEIGHT);
    else h_eff = level_height;

    w_one    = (w_eff == WW'(1));
    h_one    = (h_eff == DIM_BITS'(1));
    dw       = w_one ? WW'(1) : (w_eff >> 1);
    dh       = h_one ? DIM_BITS'(1) : (h_eff >> 1);
    col_half = col_cnt >> 1;
    row_half = row_cnt >> 1;

    // an odd trailing column or row is consumed and dropped
    x_in     = w_one || (WW'(col_cnt) < {w_eff[WW-1:1], 1'b0});
    y_in     = h_one || (DIM_BITS'(row_cnt) < {h_eff[DIM_BITS-1:1], 1'b0});
    last_col = (WW'(col_half) == dw - WW'(1));
    last_row = (DIM_BITS'(row_half) == dh - DIM_BITS'(1));
    have     = x_in && (w_one || col_cnt[0]);

    ctl_next.ld_left = x_in && !w_one && !col_cnt[0];
    ctl_next.st_wr   = have && y_in && !h_one && !row_cnt[0];
    ctl_next.emit    = have && y_in && (h_one || row_cnt[0]);
    ctl_next.w_one   = w_one;
    ctl_next.h_one   = h_one;
    ctl_next.last    = last_col && last_row;
    ctl_next.col     = col_half[AW-1:0];
  end

  // registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      level_width  <= LEVEL_WIDTH_RST;
      level_height <= LEVEL_HEIGHT_RST;
      srgb_mode    <= 1'b1;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LEVEL_WIDTH: begin
          level_width <= cfg.data;
          col_cnt     <= '0;
          row_cnt     <= '0;
        end
        REG_LEVEL_HEIGHT: begin
          level_height <= cfg.data;
          col_cnt      <= '0;
          row_cnt      <= '0;
        end
        REG_SRGB_MODE: begin
          srgb_mode <= cfg.data[0];
          col_cnt   <= '0;
          row_cnt   <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_beat) begin
      if (WW'(col_cnt) == w_eff - WW'(1)) begin
        col_cnt <= '0;
        if (DIM_BITS'(row_cnt) == h_eff - DIM_BITS'(1)) row_cnt <= '0;
        else row_cnt <= row_cnt + ROW_BITS'(1);
      end else begin
        col_cnt <= col_cnt + XW'(1);
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= pix_in.valid;
      if (adv2) v2 <= v1 && s1.emit;
      if (adv3) v3 <= v2;
      if (adv_out) out_valid <= v3;
    end
  end

  // stage 1: capture the beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1        <= ctl_next;
      s1_col[0] <= pix_in.red_in;
      s1_col[1] <= pix_in.green_in;
      s1_col[2] <= pix_in.blue_in;
      s1_alpha  <= pix_in.alpha_in;
    end
  end

  // decode and horizontal pair sum
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lin_c[c] = srgb_mode ? LIN_TAB[s1_col[c]][LB-1:0] : LB'(s1_col[c]);
      pair.col[c] = s1.w_one ? {lin_c[c], 1'b0} : (PW'(left_col[c]) + PW'(lin_c[c]));
    end
    pair.alpha = s1.w_one ? {s1_alpha, 1'b0} : (9'(left_alpha) + 9'(s1_alpha));
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1 && s1.ld_left) begin
      left_col   <= lin_c;
      left_alpha <= s1_alpha;
    end
  end

  // column store: even rows write the pair sum, odd rows read it back.
  // On odd rows the read of a column always comes at a later beat than its write.
  always_ff @(posedge clk) begin
    if (adv2 && v1 && s1.st_wr) begin
      col_store[s1.col] <= pair;
    end
    if (adv2 && v1 && s1.emit) begin
      rd_q <= col_store[s1.col];
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv2 && v1 && s1.emit) begin
      pair2  <= pair;
      h_one2 <= s1.h_one;
      last2  <= s1.last;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total_c[c] = h_one2 ? {pair2.col[c], 1'b0} : (TW'(rd_q.col[c]) + TW'(pair2.col[c]));
      avg_c[c]   = LB'((total_c[c] + TW'(2)) >> 2);
    end
    total_a = h_one2 ? {1'b0, pair2.alpha, 1'b0} : (11'(rd_q.alpha) + 11'(pair2.alpha));
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    if (LB >= SRGB_INDEX_BITS) begin : g_idx_down
      assign idx_c[c] = avg_c[c][LB-1 -: SRGB_INDEX_BITS];
    end else begin : g_idx_up
      assign idx_c[c] = SRGB_INDEX_BITS'(avg_c[c]) << (SRGB_INDEX_BITS - LB);
    end

    smbd_enc_rom #(
      .SRGB_INDEX_BITS (SRGB_INDEX_BITS)
    ) u_enc_rom (
      .clk   (clk),
      .rd_en (adv3 && v2),
      .addr  (idx_c[c]),
      .data  (enc_q[c])
    );
  end

  // stage 3; alpha average never exceeds 255
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      for (int c = 0; c < 3; c++) begin
        lin3[c] <= avg_c[c][7:0];
      end
      alpha3 <= 8'((total_a + 11'd2) >> 2);
      last3  <= last2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv_out && v3) begin
      for (int c = 0; c < 3; c++) begin
        out_col[c] <= srgb_mode ? enc_q[c] : lin3[c];
      end
      out_alpha <= alpha3;
      out_last  <= last3;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.red_out    = out_col[0];
  assign pix_out.green_out  = out_col[1];
  assign pix_out.blue_out   = out_col[2];
  assign pix_out.alpha_out  = out_alpha;
  assign pix_out.level_done = out_last;

endmodule

@@ hdl/smbd_checker.sv @@
// Port-level checks for srgb_mip_box_downsample_top, attached by bind.
// Depends only on the top level's ports.
module smbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out,
  input logic       level_done
);

  // reset empties the pipe
  a_rst_out_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat offered straight after reset");

  a_rst_in_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("source not ready straight after reset");

  // the source side only stalls while a result beat is offered and held off
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
      !in_ready |-> out_valid && !out_ready)
    else $error("source stalled without a stalled result beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid &&
        $stable({red_out, green_out, blue_out, alpha_out, level_done}))
    else $error("stalled result beat changed");

endmodule

bind srgb_mip_box_downsample_top smbd_checker u_smbd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pix_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .red_out    (pix_out.red_out),
  .green_out  (pix_out.green_out),
  .blue_out   (pix_out.blue_out),
  .alpha_out  (pix_out.alpha_out),
  .level_done (pix_out.level_done)
);

@@ tb/tb_srgb_mip_box_downsample_top.sv @@
// Self-checking testbench for srgb_mip_box_downsample_top: directed table, then random levels.
// Depends on smbd_pkg and the three channel interfaces; results checked against a local model.
`timescale 1ns / 1ps

module tb_srgb_mip_box_downsample_top;
  import smbd_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int STORE_DEPTH   = MAX_WIDTH_DEF / 2;
  localparam int ENC_SIZE      = 1 << SRGB_INDEX_BITS_DEF;
  localparam int ENC_SHIFT     = LINEAR_BITS_DEF - SRGB_INDEX_BITS_DEF;
  localparam longint unsigned LIN_MAX = (64'd1 << LINEAR_BITS_DEF) - 64'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } src_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } down_pixel_t;

  typedef logic [3:0][19:0] chan_sums_t;

  typedef struct {
    bit                        is_cfg;
    logic [REG_INDEX_BITS-1:0] idx;
    logic [DIM_BITS-1:0]       data;
    src_pixel_t                px;
    bit                        typed;
    down_pixel_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smbd_pix_in_if  pix_in ();
  smbd_pix_out_if pix_out ();
  smbd_cfg_if     cfg ();

  srgb_mip_box_downsample_top uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  always #CLK_HALF clk = ~clk;

  // gamma tables and model state
  logic [15:0] srgb_to_linear [256];
  logic [7:0]  linear_to_srgb [ENC_SIZE];
  chan_sums_t  column_sums [STORE_DEPTH];
  chan_sums_t  left_pixel;
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  logic        srgb_reg;
  logic [11:0] col_pos;
  logic [11:0] row_pos;

  down_pixel_t expected_pixels [$];
  stim_row_t   directed_rows [$];

  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_sent     = 0;
  int unsigned settings_count  = 0;
  int unsigned cycle_count     = 0;
  bit          burst_mode      = 1'b0;
  bit          sink_free       = 1'b0;

  task automatic queue_expected(down_pixel_t p);
    expected_pixels.insert(expected_pixels.size(), p);
  endtask

  task automatic add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // decode curve in Q30 at half-step code k; fifth root of X^12 by bisection
  function automatic longint unsigned gamma_curve_q30(int unsigned k);
    longint unsigned kk, x, x4, x12, lo, hi, mid, y2, y5;
    kk = k;
    if (k <= 20) return (((kk * 64'd100) << 30) + 64'd329460) / 64'd658920;
    x   = (((kk * 64'd1000 + 64'd28050) << 30) + 64'd269025) / 64'd538050;
    x4  = q30_mul(q30_mul(x, x), q30_mul(x, x));
    x12 = q30_mul(q30_mul(x4, x4), x4);
    lo  = 0;
    hi  = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      y2  = q30_mul(mid, mid);
      y5  = q30_mul(q30_mul(y2, y2), mid);
      if (y5 <= x12) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  task automatic build_gamma_tables();
    longint unsigned thr [256];
    longint unsigned centre;
    int unsigned v, i, b;
    for (v = 0; v < 256; v++) begin
      srgb_to_linear[v] = 16'((gamma_curve_q30(2 * v) * LIN_MAX + (64'd1 << 29)) >> 30);
      thr[v] = (v == 0) ? 64'd0 : gamma_curve_q30(2 * v - 1);
    end
    b = 0;
    // each encode entry takes the byte whose bucket holds the entry's centre
    for (i = 0; i < ENC_SIZE; i++) begin
      centre = longint'(2 * i + 1) << (29 - SRGB_INDEX_BITS_DEF);
      while (b < 255 && thr[b + 1] <= centre) b++;
      linear_to_srgb[i] = 8'(b);
    end
  endtask

  function automatic int unsigned clamp_dim(int unsigned d, int unsigned top);
    if (d < 1) return 1;
    if (d > top) return top;
    return d;
  endfunction

  task automatic apply_register(logic [REG_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
    bit hit;
    hit = 1'b1;
    case (idx)
      REG_LEVEL_WIDTH: begin
        width_reg = data;
      end
      REG_LEVEL_HEIGHT: begin
        height_reg = data;
      end
      REG_SRGB_MODE: begin
        srgb_reg = data[0];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    // any real register write restarts the level
    if (hit) begin
      col_pos    = '0;
      row_pos    = '0;
      left_pixel = '0;
    end
  endtask

  task automatic predict_pixel(input src_pixel_t px, output bit got, output down_pixel_t res);
    int unsigned w, h, dw, dh, x, y, col, avg, c;
    logic [3:0][7:0] bytes;
    logic [3:0][7:0] outb;
    chan_sums_t lin, pair, total;
    bit have, done;
    bytes = {px.alpha, px.blue, px.green, px.red};
    w  = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h  = clamp_dim(height_reg, MAX_HEIGHT);
    dw = (w > 1) ? w / 2 : 1;
    dh = (h > 1) ? h / 2 : 1;
    x  = col_pos;
    y  = row_pos;
    pair  = '0;
    total = '0;
    outb  = '0;
    have  = 1'b0;
    done  = 1'b0;
    got   = 1'b0;
    res   = '0;
    for (c = 0; c < 4; c++)
      lin[c] = (srgb_reg && c < 3) ? 20'(srgb_to_linear[bytes[c]]) : 20'(bytes[c]);
    if (x < 2 * dw) begin
      if (w == 1) begin
        for (c = 0; c < 4; c++) pair[c] = 2 * lin[c];
        have = 1'b1;
      end else if (x % 2 == 0) begin
        left_pixel = lin;
      end else begin
        for (c = 0; c < 4; c++) pair[c] = left_pixel[c] + lin[c];
        have = 1'b1;
      end
    end
    if (have && y < 2 * dh) begin
      col = (x >> 1) % STORE_DEPTH;
      if (h == 1) begin
        for (c = 0; c < 4; c++) total[c] = 2 * pair[c];
        done = 1'b1;
      end else if (y % 2 == 0) begin
        column_sums[col] = pair;
      end else begin
        for (c = 0; c < 4; c++) total[c] = column_sums[col][c] + pair[c];
        done = 1'b1;
      end
    end
    if (done) begin
      for (c = 0; c < 4; c++) begin
        avg = (total[c] + 2) >> 2;
        if (srgb_reg && c < 3) outb[c] = linear_to_srgb[(avg >> ENC_SHIFT) % ENC_SIZE];
        else outb[c] = (avg > 255) ? 8'd255 : 8'(avg);
      end
      res.red   = outb[0];
      res.green = outb[1];
      res.blue  = outb[2];
      res.alpha = outb[3];
      res.done  = ((x >> 1) == dw - 1) && ((y >> 1) == dh - 1);
      got = 1'b1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = 12'(x);
    row_pos = 12'(y);
  endtask

  function automatic stim_row_t cfg_row(logic [REG_INDEX_BITS-1:0] idx, int unsigned data);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: DIM_BITS'(data), px: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, px: '{r, g, b, a}, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t pix_row_exp(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a, logic [7:0] er, logic [7:0] eg,
                                            logic [7:0] eb, logic [7:0] ea, logic ed);
    stim_row_t row;
    row       = pix_row(r, g, b, a);
    row.typed = 1'b1;
    row.want  = '{er, eg, eb, ea, ed};
    return row;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 15) return $urandom_range(3, 15);
    if (r < 19) begin
      case ($urandom_range(0, 3))
        0: return 4096;
        1: return 8191;
        2: return $urandom_range(4097, 8191);
        default: return 2048;
      endcase
    end
    return 1 << $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // block must be empty before a register write; trailing ignored pixels need the drain
  task automatic wait_idle();
    pix_in.valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [REG_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
    wait_idle();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_pixel(src_pixel_t px, int unsigned gap, bit typed, down_pixel_t want);
    bit got;
    down_pixel_t res;
    if (gap > 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid    = 1'b1;
    pix_in.red_in   = px.red;
    pix_in.green_in = px.green;
    pix_in.blue_in  = px.blue;
    pix_in.alpha_in = px.alpha;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    predict_pixel(px, got, res);
    if (typed) begin
      res = want;
      got = 1'b1;
    end
    if (got) queue_expected(res);
    pixels_sent++;
    @(negedge clk);
  endtask

  // downstream hold-off: mostly short stalls, now and then a long one
  always @(negedge clk) begin : sink_stalls
    int unsigned r;
    static int unsigned hold = 0;
    static logic level = 1'b1;
    if (hold == 0) begin
      if (sink_free) begin
        level = 1'b1;
        hold  = 16;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          level = 1'b1;
          hold  = $urandom_range(1, 30);
        end else if (r < 93) begin
          level = 1'b0;
          hold  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(10, 60);
        end
      end
    end
    pix_out.ready = level;
    hold--;
  end

  always @(posedge clk) begin : check_out
    down_pixel_t got, want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out,
              pix_out.level_done};
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected beat r%02h g%02h b%02h a%02h done %0b", $realtime,
                   got.red, got.green, got.blue, got.alpha, got.done);
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.done !== want.done) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: pixel %0d got r%02h g%02h b%02h a%02h done %0b",
                     $realtime, results_checked, got.red, got.green, got.blue, got.alpha,
                     got.done);
            $display("    want r%02h g%02h b%02h a%02h done %0b",
                     want.red, want.green, want.blue, want.alpha, want.done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[srgb_mip_box_downsample_top] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    src_pixel_t  px;
    int unsigned random_pixels, w_sel, h_sel, level_px, count, i;
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;

    build_gamma_tables();
    width_reg  = LEVEL_WIDTH_RST;
    height_reg = LEVEL_HEIGHT_RST;
    srgb_reg   = 1'b1;
    col_pos    = '0;
    row_pos    = '0;
    left_pixel = '0;
    for (i = 0; i < STORE_DEPTH; i++) column_sums[i] = '0;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // 1x1 level, plain average: each pixel comes straight back
    add_row(cfg_row(REG_LEVEL_WIDTH, 1));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 1));
    add_row(cfg_row(REG_SRGB_MODE, 0));
    add_row(pix_row_exp(0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(pix_row_exp(255, 255, 255, 255, 255, 255, 255, 255, 1));
    add_row(pix_row_exp(8'h5A, 8'hA5, 8'h0F, 8'hF0,
                        8'h5A, 8'hA5, 8'h0F, 8'hF0, 1));
    // sRGB: black and white survive the round trip
    add_row(cfg_row(REG_SRGB_MODE, 1));
    add_row(pix_row_exp(0, 0, 0, 255, 0, 0, 0, 255, 1));
    add_row(pix_row_exp(255, 255, 255, 0, 255, 255, 255, 0, 1));
    add_row(pix_row(8'h80, 8'h40, 8'h20, 8'h10));
    // one full 2x2 block in linear light
    add_row(cfg_row(REG_LEVEL_WIDTH, 2));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 2));
    add_row(pix_row(255, 0, 128, 0));
    add_row(pix_row(0, 255, 128, 255));
    add_row(pix_row(30, 200, 7, 100));
    add_row(pix_row(255, 255, 0, 1));
    // zero sizes act as one; only bit 0 of the mode register counts
    add_row(cfg_row(REG_LEVEL_WIDTH, 0));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 0));
    add_row(cfg_row(REG_SRGB_MODE, 13'h1FFE));
    add_row(pix_row_exp(1, 2, 3, 4, 1, 2, 3, 4, 1));
    // odd width: third column is eaten
    add_row(cfg_row(REG_LEVEL_WIDTH, 3));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 1));
    add_row(cfg_row(REG_SRGB_MODE, 1));
    add_row(pix_row(200, 10, 90, 33));
    add_row(pix_row(17, 250, 91, 34));
    add_row(pix_row(255, 255, 255, 255));
    // single column over two rows; the spare index must not restart the level
    add_row(cfg_row(REG_LEVEL_WIDTH, 1));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 2));
    add_row(pix_row(10, 20, 30, 40));
    add_row(cfg_row(REG_SPARE, 13'h1FFF));
    add_row(pix_row(50, 60, 70, 80));
    // oversize width clamps to the maximum
    add_row(cfg_row(REG_LEVEL_WIDTH, 8191));
    add_row(cfg_row(REG_LEVEL_HEIGHT, 1));
    add_row(cfg_row(REG_SRGB_MODE, 0));
    add_row(pix_row(255, 255, 255, 255));
    add_row(pix_row(0, 0, 0, 1));

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_cfg) begin
        write_register(row.idx, row.data);
        settings_count++;
      end else begin
        send_pixel(row.px, pick_gap(), row.typed, row.want);
      end
    end

    random_pixels = 0;
    while (random_pixels < RANDOM_ITEMS) begin
      w_sel = pick_dim();
      h_sel = (w_sel > 64 && $urandom_range(0, 3) != 0) ? 1 : pick_dim();
      write_register(REG_LEVEL_WIDTH, DIM_BITS'(w_sel));
      write_register(REG_LEVEL_HEIGHT, DIM_BITS'(h_sel));
      write_register(REG_SRGB_MODE, DIM_BITS'($urandom_range(0, 8191)));
      if ($urandom_range(0, 7) == 0)
        write_register(REG_SPARE, DIM_BITS'($urandom_range(0, 8191)));
      settings_count++;
      level_px = clamp_dim(w_sel, MAX_WIDTH_DEF) * clamp_dim(h_sel, MAX_HEIGHT);
      // whole levels (wrap included) when small, a partial stretch when large
      if (level_px <= 512) begin
        count = level_px * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, level_px);
      end else begin
        count = $urandom_range(64, 320);
      end
      if (count > RANDOM_ITEMS - random_pixels) count = RANDOM_ITEMS - random_pixels;
      burst_mode = ($urandom_range(0, 4) == 0);
      sink_free  = ($urandom_range(0, 4) == 0);
      repeat (count) begin
        px = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_pixel(px, pick_gap(), 1'b0, '0);
        random_pixels++;
      end
    end

    burst_mode = 1'b0;
    sink_free  = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d register settings (sizes 0 to 8191, both colour modes)",
             settings_count);
    $display("%0d source pixels sent, %0d downsampled pixels checked, %0d failures",
             pixels_sent, results_checked, fail_count);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("[srgb_mip_box_downsample_top] OK");
    end else begin
      $display("[srgb_mip_box_downsample_top] ERROR");
    end
    $finish;
  end

endmodule
